[rtl/core/pfla_pkg.sv]
// Shared types and constants for the page free-list allocator.
package pfla_pkg;

  localparam int unsigned PAGE_W     = 20;
  localparam int unsigned TOP_W      = 21;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CNT_OUT_W  = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [TOP_W-1:0] PAGE_LIMIT = 21'h100000;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_PAGE   = 1'b1;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_INIT  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_BADADDR = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC_WAIT,
    ST_INIT
  } state_e;

  typedef struct packed {
    logic    pop;
    logic    push_in;
    logic    push_cur;
    logic    cur_load;
    logic    out_ld;
    logic    out_use_rd;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic cur_done;
    logic bad_addr;
    logic out_valid;
  } sts_t;

endpackage

[rtl/core/pfla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pfla_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/pfla_ctrl.sv]
// Request sequencer: decodes each request and steps the datapath.
module pfla_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic [1:0]    kind_i,
  input  logic          m_tready_i,
  input  pfla_pkg::sts_t sts_i,
  output pfla_pkg::cmd_t cmd_o,
  output logic          s_tready_o
);

  pfla_pkg::state_e state_q, state_d;
  logic             accept;

  assign s_tready_o = (state_q == pfla_pkg::ST_IDLE) && (!sts_i.out_valid || m_tready_i);
  assign accept     = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfla_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfla_pkg::ST_IDLE: begin
        if (accept) begin
          if (kind_i == pfla_pkg::KIND_ALLOC && !sts_i.empty) begin
            state_d = pfla_pkg::ST_ALLOC_WAIT;
          end else if (kind_i == pfla_pkg::KIND_INIT) begin
            state_d = pfla_pkg::ST_INIT;
          end
        end
      end
      pfla_pkg::ST_ALLOC_WAIT: state_d = pfla_pkg::ST_IDLE;
      pfla_pkg::ST_INIT: begin
        if (sts_i.cur_done || sts_i.full) begin
          state_d = pfla_pkg::ST_IDLE;
        end
      end
      default: state_d = pfla_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = pfla_pkg::STAT_OK;
    case (state_q)
      pfla_pkg::ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            pfla_pkg::KIND_ALLOC: begin
              if (sts_i.empty) begin
                cmd_o.out_ld     = 1'b1;
                cmd_o.out_status = pfla_pkg::STAT_EMPTY;
              end else begin
                cmd_o.pop = 1'b1;
              end
            end
            pfla_pkg::KIND_FREE: begin
              cmd_o.out_ld = 1'b1;
              if (sts_i.bad_addr) begin
                cmd_o.out_status = pfla_pkg::STAT_BADADDR;
              end else if (sts_i.full) begin
                cmd_o.out_status = pfla_pkg::STAT_FULL;
              end else begin
                cmd_o.push_in = 1'b1;
              end
            end
            pfla_pkg::KIND_INIT: cmd_o.cur_load = 1'b1;
            default: cmd_o.out_ld = 1'b1;
          endcase
        end
      end
      pfla_pkg::ST_ALLOC_WAIT: begin
        cmd_o.out_ld     = 1'b1;
        cmd_o.out_use_rd = 1'b1;
      end
      pfla_pkg::ST_INIT: begin
        if (sts_i.cur_done) begin
          cmd_o.out_ld = 1'b1;
        end else if (sts_i.full) begin
          cmd_o.out_ld     = 1'b1;
          cmd_o.out_status = pfla_pkg::STAT_FULL;
        end else begin
          cmd_o.push_cur = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_pop_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |=> state_q == pfla_pkg::ST_ALLOC_WAIT)
    else $error("pop not followed by read-data cycle");

  a_fill_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push_cur |-> !sts_i.full && !sts_i.cur_done)
    else $error("init push past limit");

  a_init_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfla_pkg::ST_INIT && !$past(state_q == pfla_pkg::ST_INIT))
      |-> $past(cmd_o.cur_load))
    else $error("init walk started without cursor load");

endmodule

[rtl/core/pfla_dp.sv]
// Datapath: config registers, stack count, init cursor, page store, result register.
module pfla_dp #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned MAX_PAGES  = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pfla_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pfla_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [pfla_pkg::ADDR_W-1:0]         page_addr_i,
  input  logic                                m_tready_i,
  input  pfla_pkg::cmd_t                      cmd_i,
  output pfla_pkg::sts_t                      sts_o,
  output logic                                m_tvalid_o,
  output logic [pfla_pkg::OUT_DATA_W-1:0]     m_tdata_o
);

  localparam int unsigned SH = $clog2(PAGE_BYTES);
  localparam int unsigned CW = $clog2(MAX_PAGES + 1);
  localparam int unsigned AW = $clog2(MAX_PAGES);

  logic [pfla_pkg::PAGE_W-1:0]    first_q;
  logic [pfla_pkg::TOP_W-1:0]     top_q;
  logic [pfla_pkg::TOP_W-1:0]     top_lim;
  logic [CW-1:0]                  count_q, count_d, count_m1;
  logic [pfla_pkg::TOP_W-1:0]     cursor_q, cursor_d;
  logic [pfla_pkg::ADDR_W-1:0]    in_page;
  logic                           aligned;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr, ram_raddr;
  logic [pfla_pkg::PAGE_W-1:0]    ram_wdata, ram_rdata;
  logic [51:0]                    rd_addr_wide;
  logic [CW+pfla_pkg::CNT_OUT_W-1:0] count_ext;
  logic                           out_valid_q, out_valid_d;
  logic [pfla_pkg::ADDR_W-1:0]    out_addr_q;
  pfla_pkg::status_e              out_status_q;
  logic [pfla_pkg::CNT_OUT_W-1:0] out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      top_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pfla_pkg::CFG_FIRST_PAGE) begin
        first_q <= cfg_data_i[pfla_pkg::PAGE_W-1:0];
      end
      if (cfg_idx_i == pfla_pkg::CFG_TOP_PAGE) begin
        top_q <= cfg_data_i[pfla_pkg::TOP_W-1:0];
      end
    end
  end

  assign top_lim = (top_q > pfla_pkg::PAGE_LIMIT) ? pfla_pkg::PAGE_LIMIT : top_q;

  // free request checks
  assign in_page = page_addr_i >> SH;
  assign aligned = (page_addr_i[SH-1:0] == '0);

  assign sts_o.bad_addr = !aligned
                        || (in_page < pfla_pkg::ADDR_W'(first_q))
                        || (in_page >= pfla_pkg::ADDR_W'(top_lim));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.full      = (count_q >= CW'(MAX_PAGES));
  assign sts_o.cur_done  = (cursor_q >= top_lim);
  assign sts_o.out_valid = out_valid_q;

  assign count_m1 = count_q - CW'(1);

  always_comb begin
    count_d = count_q;
    if (cmd_i.pop) begin
      count_d = count_m1;
    end else if (cmd_i.push_in || cmd_i.push_cur) begin
      count_d = count_q + CW'(1);
    end
  end

  always_comb begin
    cursor_d = cursor_q;
    if (cmd_i.cur_load) begin
      cursor_d = pfla_pkg::TOP_W'(first_q);
    end else if (cmd_i.push_cur) begin
      cursor_d = cursor_q + pfla_pkg::TOP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

  // page store, top of stack at count - 1
  assign ram_we    = cmd_i.push_in || cmd_i.push_cur;
  assign ram_waddr = count_q[AW-1:0];
  assign ram_wdata = cmd_i.push_cur ? cursor_q[pfla_pkg::PAGE_W-1:0]
                                    : in_page[pfla_pkg::PAGE_W-1:0];
  assign ram_raddr = count_m1[AW-1:0];

  pfla_ram #(
    .WIDTH (pfla_pkg::PAGE_W),
    .DEPTH (MAX_PAGES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.pop),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_addr_wide = 52'(ram_rdata) << SH;
  assign count_ext    = (CW + pfla_pkg::CNT_OUT_W)'(count_d);

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_ld) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_addr_q   <= cmd_i.out_use_rd ? rd_addr_wide[pfla_pkg::ADDR_W-1:0] : '0;
      out_status_q <= cmd_i.out_status;
      out_count_q  <= count_ext[pfla_pkg::CNT_OUT_W-1:0];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {2'b00, out_count_q, out_status_q, out_addr_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_PAGES))
    else $error("stack count above capacity");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !sts_o.empty && !ram_we)
    else $error("pop on empty store or with a write");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> !out_valid_q || m_tready_i)
    else $error("pending result overwritten");

endmodule

[rtl/core/page_free_list_allocator_unit.sv]
// Top level of the page free-list allocator: LIFO store of free page numbers.
//
// channel  direction  tdata (low bit up)                          tuser
// s_axis   in         page_addr[31:0]                             kind[1:0]
// m_axis   out        alloc_addr[31:0] status[33:32] free_count[45:34] -
// cfg      in         write enable, index, data (0 first_page, 1 top_page)
//
// One request at a time. Free and unused kinds: result registered in the cycle after accept.
// Alloc: through the registered page-store RAM read, then the output register; empty: direct.
// Init: one page-store write per cycle for the N pages pushed, then the result is registered.
// Reset is asynchronous; count and cursor clear at once, the page store is not cleared.
// A result not yet taken holds the output register and blocks the next request.
module page_free_list_allocator_unit #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned MAX_PAGES  = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pfla_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pfla_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pfla_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // page_addr
  input  logic [pfla_pkg::IN_USER_W-1:0]      s_axis_tuser,  // kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pfla_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // alloc_addr, status, free_count
);

  pfla_pkg::cmd_t cmd;
  pfla_pkg::sts_t sts;

  pfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .kind_i     (s_axis_tuser),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .s_tready_o (s_axis_tready)
  );

  pfla_dp #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_PAGES  (MAX_PAGES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .page_addr_i (s_axis_tdata),
    .m_tready_i  (m_axis_tready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule
